// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/h2fc_pkg.sv =====
package h2fc_pkg;

	typedef enum logic [1:0] {
		PH_PREFACE  = 2'd0,
		PH_SETTINGS = 2'd1,
		PH_OPEN     = 2'd2,
		PH_CLOSED   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_PLAIN   = 2'd0,
		EV_HEADERS = 2'd1,
		EV_DATA    = 2'd2
	} ev_kind_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FAIL   = 2'd1;
	localparam logic [1:0] ST_CLOSED = 2'd2;

	localparam logic [7:0] TYPE_DATA     = 8'd0;
	localparam logic [7:0] TYPE_HEADERS  = 8'd1;
	localparam logic [7:0] TYPE_SETTINGS = 8'd4;
	localparam logic [7:0] TYPE_GOAWAY   = 8'd7;

	localparam int         FLAG_ACK_BIT     = 0;
	localparam logic [15:0] SETTING_MAX_CONC = 16'd3;

	localparam logic [4:0] PREFACE_LAST = 5'd23;
	localparam logic [4:0] HDR_LAST     = 5'd8;
	localparam logic [4:0] PAYLOAD_POS  = 5'd9;
	localparam logic [2:0] ENTRY_LAST   = 3'd5;
	localparam logic [24:0] PREFACE_LEN = 25'd24;
	localparam logic [24:0] HDR_LEN     = 25'd9;
	localparam logic [23:0] MAX_LEN_RESET = 24'd16384;

	// One finished unit on its way from the front end to the back end.
	typedef struct packed {
		ev_kind_t    kind;
		logic [1:0]  status;
		logic        is_preface;
		logic [7:0]  frame_type;
		logic [30:0] stream_id;
		logic [24:0] consumed_len;
		phase_t      conn_phase;
	} event_t;

	// Stream table decision returned to the front end.
	typedef struct packed {
		logic valid;
		logic fail;
	} verdict_t;

	function automatic logic [7:0] preface_byte(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0:  r = 8'h50;
			5'd1:  r = 8'h52;
			5'd2:  r = 8'h49;
			5'd3:  r = 8'h20;
			5'd4:  r = 8'h2a;
			5'd5:  r = 8'h20;
			5'd6:  r = 8'h48;
			5'd7:  r = 8'h54;
			5'd8:  r = 8'h54;
			5'd9:  r = 8'h50;
			5'd10: r = 8'h2f;
			5'd11: r = 8'h32;
			5'd12: r = 8'h2e;
			5'd13: r = 8'h30;
			5'd14: r = 8'h0d;
			5'd15: r = 8'h0a;
			5'd16: r = 8'h0d;
			5'd17: r = 8'h0a;
			5'd18: r = 8'h53;
			5'd19: r = 8'h4d;
			5'd20: r = 8'h0d;
			5'd21: r = 8'h0a;
			5'd22: r = 8'h0d;
			5'd23: r = 8'h0a;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/h2fc_in_if.sv =====
interface h2fc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/h2fc_out_if.sv =====
interface h2fc_out_if #(parameter int CNT_W = 5);
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             is_preface;
	logic [7:0]       frame_type;
	logic [30:0]      stream_id;
	logic [24:0]      consumed_len;
	logic [1:0]       conn_phase;
	logic [CNT_W-1:0] open_streams;

	modport source (output valid, output status, output is_preface, output frame_type,
		output stream_id, output consumed_len, output conn_phase, output open_streams,
		input ready);
	modport sink (input valid, input status, input is_preface, input frame_type,
		input stream_id, input consumed_len, input conn_phase, input open_streams,
		output ready);
endinterface

// ===== hw/rtl/h2fc_front.sv =====
`include "assert_macros.svh"

module h2fc_front #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [23:0]         cfg_wr_data,
	h2fc_in_if.sink             rx,
	output logic                ev_push,
	output h2fc_pkg::event_t    ev,
	input  logic                ev_room,
	input  h2fc_pkg::verdict_t  verdict
);

	h2fc_pkg::phase_t phase_q, phase_d;
	logic [4:0]  pos_q, pos_d;
	logic [23:0] hlen_q, hlen_d, hlen_n;
	logic [7:0]  htype_q, htype_d, htype_n;
	logic [7:0]  hflags_q, hflags_d, hflags_n;
	logic [30:0] hsid_q, hsid_d, hsid_n;
	logic [23:0] rem_q, rem_d;
	logic [2:0]  ebi_q, ebi_d, ebi_u;
	logic [15:0] eid_q, eid_d, eid_n;
	logic [31:0] eval_q, eval_d, eval_n;
	logic        seen_q, seen_d, seen_u;
	logic        inval_q, inval_d, inval_u, pre_inval;
	logic        wait_q, wait_d;
	logic [23:0] maxlen_q;

	logic [7:0]  b;
	logic        accept, at_hdr_end, in_payload, oversize, ent_end, conc, bad, hit_done;
	logic [7:0]  d_type, d_flags;
	logic [30:0] d_sid;
	logic [23:0] d_len;
	logic        d_seen, d_inval, d_mod6ok, d_fail;
	logic [24:0] d_full, d_consumed;
	h2fc_pkg::ev_kind_t d_kind;
	h2fc_pkg::phase_t   d_phase;

	assign b        = rx.data_byte;
	assign rx.ready = !wait_q && ev_room;
	assign accept   = rx.valid && rx.ready;

	// Field capture, settings entry decode and the end-of-frame verdict.
	always_comb begin
		hlen_n   = hlen_q;
		htype_n  = htype_q;
		hflags_n = hflags_q;
		hsid_n   = hsid_q;
		case (pos_q)
			5'd0: hlen_n = {b, 16'h0};
			5'd1: hlen_n = hlen_q | {8'h0, b, 8'h0};
			5'd2: hlen_n = hlen_q | {16'h0, b};
			5'd3: htype_n = b;
			5'd4: hflags_n = b;
			5'd5: hsid_n = {b[6:0], 24'h0};
			5'd6: hsid_n = hsid_q | {7'h0, b, 16'h0};
			5'd7: hsid_n = hsid_q | {15'h0, b, 8'h0};
			5'd8: hsid_n = hsid_q | {23'h0, b};
			default: hsid_n = hsid_q;
		endcase

		pre_inval = inval_q | (b != h2fc_pkg::preface_byte(pos_q));

		eid_n   = (ebi_q < 3'd2) ? {eid_q[7:0], b} : eid_q;
		eval_n  = (ebi_q >= 3'd2) ? {eval_q[23:0], b} : eval_q;
		ent_end = ebi_q >= h2fc_pkg::ENTRY_LAST;
		conc    = eid_n == h2fc_pkg::SETTING_MAX_CONC;
		bad     = (eval_n == 32'd0) || (eval_n > 32'(TABLE_DEPTH));
		seen_u  = seen_q | (ent_end && conc && !bad);
		inval_u = inval_q | (ent_end && conc && bad);
		ebi_u   = ent_end ? 3'd0 : ebi_q + 3'd1;

		at_hdr_end = pos_q == h2fc_pkg::HDR_LAST;
		in_payload = pos_q == h2fc_pkg::PAYLOAD_POS;
		oversize   = hlen_n > maxlen_q;

		if (at_hdr_end) begin
			d_type   = htype_n;
			d_flags  = hflags_n;
			d_sid    = hsid_n;
			d_len    = hlen_n;
			d_seen   = 1'b0;
			d_inval  = 1'b0;
			d_mod6ok = 1'b1;
		end else begin
			d_type   = htype_q;
			d_flags  = hflags_q;
			d_sid    = hsid_q;
			d_len    = hlen_q;
			d_seen   = seen_u;
			d_inval  = inval_u;
			// The entry byte counter wraps every six bytes, so it lands on zero
			// exactly when the payload length is a multiple of six.
			d_mod6ok = ebi_u == 3'd0;
		end
		d_full = h2fc_pkg::HDR_LEN + {1'b0, d_len};

		d_fail     = 1'b0;
		d_kind     = h2fc_pkg::EV_PLAIN;
		d_consumed = d_full;
		if (phase_q == h2fc_pkg::PH_SETTINGS) begin
			if (d_type != h2fc_pkg::TYPE_SETTINGS || d_sid != 31'd0 ||
				d_flags[h2fc_pkg::FLAG_ACK_BIT])
				d_fail = 1'b1;
			if (d_len != 24'd0 && (!d_mod6ok || d_inval || !d_seen))
				d_fail = 1'b1;
			if (d_fail)
				d_consumed = 25'd0;
		end else begin
			case (d_type)
				h2fc_pkg::TYPE_GOAWAY: d_fail = 1'b1;
				h2fc_pkg::TYPE_SETTINGS: begin
					d_fail = d_sid != 31'd0;
					if (d_fail)
						d_consumed = 25'd0;
				end
				h2fc_pkg::TYPE_HEADERS: begin
					d_fail = !d_sid[0];
					if (d_fail)
						d_consumed = 25'd0;
					else
						d_kind = h2fc_pkg::EV_HEADERS;
				end
				h2fc_pkg::TYPE_DATA: d_kind = h2fc_pkg::EV_DATA;
				default: begin
					d_fail     = 1'b1;
					d_consumed = 25'd0;
				end
			endcase
		end
		d_phase = d_fail ? h2fc_pkg::PH_CLOSED : h2fc_pkg::PH_OPEN;

		hit_done = (phase_q == h2fc_pkg::PH_SETTINGS || phase_q == h2fc_pkg::PH_OPEN) &&
			((at_hdr_end && !oversize && hlen_n == 24'd0) ||
			(in_payload && rem_q == 24'd1));
	end

	// Next state.
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		hlen_d   = hlen_q;
		htype_d  = htype_q;
		hflags_d = hflags_q;
		hsid_d   = hsid_q;
		rem_d    = rem_q;
		ebi_d    = ebi_q;
		eid_d    = eid_q;
		eval_d   = eval_q;
		seen_d   = seen_q;
		inval_d  = inval_q;
		wait_d   = wait_q;
		if (verdict.valid) begin
			wait_d = 1'b0;
			if (verdict.fail)
				phase_d = h2fc_pkg::PH_CLOSED;
		end
		if (accept) begin
			case (phase_q)
				h2fc_pkg::PH_CLOSED: phase_d = h2fc_pkg::PH_CLOSED;
				h2fc_pkg::PH_PREFACE: begin
					inval_d = pre_inval;
					pos_d   = pos_q + 5'd1;
					if (pos_q == h2fc_pkg::PREFACE_LAST) begin
						pos_d   = 5'd0;
						inval_d = 1'b0;
						phase_d = pre_inval ? h2fc_pkg::PH_CLOSED : h2fc_pkg::PH_SETTINGS;
					end
				end
				default: begin
					if (!in_payload) begin
						hlen_d   = hlen_n;
						htype_d  = htype_n;
						hflags_d = hflags_n;
						hsid_d   = hsid_n;
						pos_d    = pos_q + 5'd1;
						if (at_hdr_end) begin
							if (oversize) begin
								pos_d   = 5'd0;
								phase_d = h2fc_pkg::PH_CLOSED;
							end else begin
								rem_d   = hlen_n;
								ebi_d   = 3'd0;
								eid_d   = 16'd0;
								eval_d  = 32'd0;
								seen_d  = 1'b0;
								inval_d = 1'b0;
							end
						end
					end else begin
						if (phase_q == h2fc_pkg::PH_SETTINGS) begin
							ebi_d   = ebi_u;
							eid_d   = ent_end ? 16'd0 : eid_n;
							eval_d  = ent_end ? 32'd0 : eval_n;
							seen_d  = seen_u;
							inval_d = inval_u;
						end
						rem_d = rem_q - 24'd1;
					end
					if (hit_done) begin
						pos_d   = 5'd0;
						phase_d = d_phase;
						wait_d  = d_kind != h2fc_pkg::EV_PLAIN;
					end
				end
			endcase
		end
	end

	// Event towards the back end.
	always_comb begin
		ev_push         = 1'b0;
		ev.kind         = h2fc_pkg::EV_PLAIN;
		ev.status       = h2fc_pkg::ST_OK;
		ev.is_preface   = 1'b0;
		ev.frame_type   = 8'd0;
		ev.stream_id    = 31'd0;
		ev.consumed_len = 25'd0;
		ev.conn_phase   = h2fc_pkg::PH_CLOSED;
		if (accept) begin
			case (phase_q)
				h2fc_pkg::PH_CLOSED: begin
					ev_push   = 1'b1;
					ev.status = h2fc_pkg::ST_CLOSED;
				end
				h2fc_pkg::PH_PREFACE: begin
					if (pos_q == h2fc_pkg::PREFACE_LAST) begin
						ev_push       = 1'b1;
						ev.is_preface = 1'b1;
						if (pre_inval) begin
							ev.status = h2fc_pkg::ST_FAIL;
						end else begin
							ev.consumed_len = h2fc_pkg::PREFACE_LEN;
							ev.conn_phase   = h2fc_pkg::PH_SETTINGS;
						end
					end
				end
				default: begin
					if (at_hdr_end && oversize) begin
						ev_push       = 1'b1;
						ev.status     = h2fc_pkg::ST_FAIL;
						ev.frame_type = htype_n;
						ev.stream_id  = hsid_n;
					end else if (hit_done) begin
						ev_push         = 1'b1;
						ev.kind         = d_kind;
						ev.status       = d_fail ? h2fc_pkg::ST_FAIL : h2fc_pkg::ST_OK;
						ev.frame_type   = d_type;
						ev.stream_id    = d_sid;
						ev.consumed_len = d_consumed;
						ev.conn_phase   = d_phase;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= h2fc_pkg::PH_PREFACE;
			pos_q    <= 5'd0;
			hlen_q   <= 24'd0;
			htype_q  <= 8'd0;
			hflags_q <= 8'd0;
			hsid_q   <= 31'd0;
			rem_q    <= 24'd0;
			ebi_q    <= 3'd0;
			eid_q    <= 16'd0;
			eval_q   <= 32'd0;
			seen_q   <= 1'b0;
			inval_q  <= 1'b0;
			wait_q   <= 1'b0;
			maxlen_q <= h2fc_pkg::MAX_LEN_RESET;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			hlen_q   <= hlen_d;
			htype_q  <= htype_d;
			hflags_q <= hflags_d;
			hsid_q   <= hsid_d;
			rem_q    <= rem_d;
			ebi_q    <= ebi_d;
			eid_q    <= eid_d;
			eval_q   <= eval_d;
			seen_q   <= seen_d;
			inval_q  <= inval_d;
			wait_q   <= wait_d;
			if (cfg_wr_en)
				maxlen_q <= cfg_wr_data;
		end
	end

	`ASSERT_IMPLIES(a_wait_blocks_input, wait_q, !rx.ready, "input taken during table lookup")
	`ASSERT_NEXT(a_closed_sticks, phase_q == h2fc_pkg::PH_CLOSED,
		phase_q == h2fc_pkg::PH_CLOSED, "connection left the closed phase")

endmodule

// ===== hw/rtl/h2fc_evq.sv =====
module h2fc_evq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  h2fc_pkg::event_t din,
	output logic             room,
	output logic             valid,
	input  logic             pop,
	output h2fc_pkg::event_t dout
);

	h2fc_pkg::event_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign room  = cnt_q != 2'd2;
	assign valid = cnt_q != 2'd0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== hw/rtl/h2fc_back.sv =====
`include "assert_macros.svh"

module h2fc_back #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  h2fc_pkg::event_t   q_ev,
	output logic               q_pop,
	output h2fc_pkg::verdict_t verdict,
	h2fc_out_if.source         res
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [30:0]      tab_q [TABLE_DEPTH];
	logic [CNT_W-1:0] total_q, total_n;
	logic             ov_q;
	logic             hit, fail, add, take;

	logic [1:0]       st_q;
	logic             pre_q;
	logic [7:0]       type_q;
	logic [30:0]      sid_q;
	logic [24:0]      len_q;
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] open_q;

	assign take  = q_valid && (!ov_q || res.ready);
	assign q_pop = take;

	// All live table entries are compared at once.
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (CNT_W'(i) < total_q && tab_q[i] == q_ev.stream_id)
				hit = 1'b1;
		end
	end

	always_comb begin
		fail = 1'b0;
		add  = 1'b0;
		case (q_ev.kind)
			h2fc_pkg::EV_HEADERS: begin
				if (!hit) begin
					if (total_q >= CNT_W'(TABLE_DEPTH))
						fail = 1'b1;
					else
						add = 1'b1;
				end
			end
			h2fc_pkg::EV_DATA: fail = !hit;
			default: fail = 1'b0;
		endcase
		total_n = add ? total_q + CNT_W'(1) : total_q;
		verdict.valid = take && (q_ev.kind != h2fc_pkg::EV_PLAIN);
		verdict.fail  = fail;
	end

	always_ff @(posedge clk) begin
		if (take && add)
			tab_q[total_q[IDX_W-1:0]] <= q_ev.stream_id;
		if (take) begin
			st_q    <= fail ? h2fc_pkg::ST_FAIL : q_ev.status;
			pre_q   <= q_ev.is_preface;
			type_q  <= q_ev.frame_type;
			sid_q   <= q_ev.stream_id;
			len_q   <= fail ? 25'd0 : q_ev.consumed_len;
			phase_q <= fail ? h2fc_pkg::PH_CLOSED : q_ev.conn_phase;
			open_q  <= total_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (take) begin
				total_q <= total_n;
				ov_q    <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign res.valid        = ov_q;
	assign res.status       = st_q;
	assign res.is_preface   = pre_q;
	assign res.frame_type   = type_q;
	assign res.stream_id    = sid_q;
	assign res.consumed_len = len_q;
	assign res.conn_phase   = phase_q;
	assign res.open_streams = open_q;

	`ASSERT_HOLDS(a_total_bounded, total_q <= CNT_W'(TABLE_DEPTH), "stream count beyond table")
	`ASSERT_NEXT(a_fail_reported, verdict.valid && verdict.fail,
		res.valid && res.status == h2fc_pkg::ST_FAIL, "table failure not reported")

endmodule

// ===== hw/rtl/http2_connection_frame_checker.sv =====
// HTTP/2 connection checker, server side. Bytes of the received connection
// arrive on rx, one word per byte. Results leave on res: one word for the
// checked preface, one for each finished frame or oversized frame header,
// and one for every byte that arrives after the connection has been closed.
// The one configuration register, the largest accepted payload length, is
// written through cfg_wr_en and cfg_wr_data and resets to 16384.
// A result is held in the event queue and then in the result register on res.
// Throughput: one byte per cycle while rx.ready is high. After the last byte
// of a HEADERS or DATA frame the input pauses while the stream table is
// searched, longer when earlier results still wait in the queue; the table
// holds TABLE_DEPTH stream ids compared in parallel.
// A two-entry queue separates the byte parser from the result stage, so a
// stall on res lets the parser run on until the queue is full, after which
// rx.ready drops. Results are never lost while res is stalled.
// Reset clears the connection to the preface phase, empties the stream
// table and restores the length limit.
module http2_connection_frame_checker #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	h2fc_in_if.sink     rx,
	h2fc_out_if.source  res
);

	logic               ev_push, ev_room, q_valid, q_pop;
	h2fc_pkg::event_t   ev, q_ev;
	h2fc_pkg::verdict_t verdict;

	h2fc_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx),
		.ev_push     (ev_push),
		.ev          (ev),
		.ev_room     (ev_room),
		.verdict     (verdict)
	);

	h2fc_evq u_evq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (ev_push),
		.din    (ev),
		.room   (ev_room),
		.valid  (q_valid),
		.pop    (q_pop),
		.dout   (q_ev)
	);

	h2fc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ev    (q_ev),
		.q_pop   (q_pop),
		.verdict (verdict),
		.res     (res)
	);

endmodule
